### design/clr_pkg.sv
package clr_pkg;

   localparam int COORD_BITS  = 12;
   localparam int ERR_BITS    = COORD_BITS + 1;
   localparam int RES_BITS    = 13;
   localparam int PITCH_BITS  = 14;
   localparam int BPP_BITS    = 3;
   localparam int OFFSET_BITS = 26;
   localparam int COLOR_BITS  = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = PITCH_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   // two's complement step: none, +1, -1
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_POS  = 2'd1,
      DIR_NEG  = 2'd3
   } dir_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_X_RES = 2'd0,
      CSR_Y_RES = 2'd1,
      CSR_PITCH = 2'd2,
      CSR_BPP   = 2'd3
   } csr_idx_type;

   localparam logic [RES_BITS-1:0]   X_RES_RESET = RES_BITS'(640);
   localparam logic [RES_BITS-1:0]   Y_RES_RESET = RES_BITS'(480);
   localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(1920);
   localparam logic [BPP_BITS-1:0]   BPP_RESET   = BPP_BITS'(3);

   typedef struct packed {
      logic [RES_BITS-1:0]   x_res;
      logic [RES_BITS-1:0]   y_res;
      logic [PITCH_BITS-1:0] pitch;
      logic [BPP_BITS-1:0]   bpp;
   } cfg_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] offset;
      logic                   visible;
   } pix_info_type;

endpackage

### design/clr_pixel.sv
module clr_pixel (
   input  clr_pkg::cfg_type      cfg,
   input  clr_pkg::coord_type    px,
   input  clr_pkg::coord_type    py,
   output clr_pkg::pix_info_type info
);
   import clr_pkg::*;

   logic [PITCH_BITS+COORD_BITS-1:0] row_part;
   logic [BPP_BITS+COORD_BITS-1:0]   col_part;
   logic [OFFSET_BITS-1:0]           sum;

   always_comb begin
      row_part = (PITCH_BITS + COORD_BITS)'(cfg.pitch) * (PITCH_BITS + COORD_BITS)'(py);
      col_part = (BPP_BITS + COORD_BITS)'(cfg.bpp) * (BPP_BITS + COORD_BITS)'(px);
      // offset wraps to its width
      sum = OFFSET_BITS'(row_part) + OFFSET_BITS'(col_part);
      info.offset = sum;
      info.visible = (RES_BITS'(px) < cfg.x_res) && (RES_BITS'(py) < cfg.y_res);
   end

endmodule

### design/clipped_line_rasterizer.sv
// channel | ports  | beat carries
// req     | req_*  | command, endpoints, line colour
// rsp     | rsp_*  | pixel x/y, byte offset, colour, visible, last
// csr     | csr_*  | register index and write data, no handshake
//
// One beat per clock while req_ready is high: a step beat on an active line
// updates the line state and loads the result register in the same cycle;
// the pixel appears in the cycle after. Start beats load the line and give no result.
// req_ready is high whenever the result register is empty or being taken.
// Synchronous reset clears the line state and sets the register defaults.
module clipped_line_rasterizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  clr_pkg::coord_type                   req_x_start,
   input  clr_pkg::coord_type                   req_y_start,
   input  clr_pkg::coord_type                   req_x_end,
   input  clr_pkg::coord_type                   req_y_end,
   input  logic [clr_pkg::COLOR_BITS-1:0]       req_line_color,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output clr_pkg::coord_type                   rsp_pixel_x,
   output clr_pkg::coord_type                   rsp_pixel_y,
   output logic [clr_pkg::OFFSET_BITS-1:0]      rsp_byte_offset,
   output logic [clr_pkg::COLOR_BITS-1:0]       rsp_pixel_color,
   output logic                                 rsp_visible,
   output logic                                 rsp_last,
   input  logic                                 csr_write_en,
   input  logic [clr_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [clr_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import clr_pkg::*;

   function automatic coord_type step_coord(input coord_type c, input dir_type d);
      unique case (d)
         DIR_POS: step_coord = c + coord_type'(1);
         DIR_NEG: step_coord = c - coord_type'(1);
         default: step_coord = c;
      endcase
   endfunction

   cfg_type cfg_ff;

   coord_type cur_x_ff, cur_y_ff, tgt_x_ff, tgt_y_ff, major_ff, minor_ff;
   coord_type cur_x_in, cur_y_in, tgt_x_in, tgt_y_in, major_in, minor_in;
   logic [ERR_BITS-1:0] err_ff, err_in, err_sum;
   dir_type x_dir_ff, y_dir_ff, x_dir_in, y_dir_in;
   logic x_major_ff, x_major_in, active_ff, active_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   logic rsp_valid_ff, rsp_valid_in;
   coord_type rsp_x_ff, rsp_y_ff;
   logic [OFFSET_BITS-1:0] rsp_off_ff;
   logic [COLOR_BITS-1:0] rsp_color_ff;
   logic rsp_vis_ff, rsp_last_ff;
   logic load_rsp;

   logic accept, fin;
   coord_type dx, dy;
   pix_info_type info;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   clr_pixel u_pixel (
      .cfg  (cfg_ff),
      .px   (cur_x_ff),
      .py   (cur_y_ff),
      .info (info)
   );

   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      tgt_x_in   = tgt_x_ff;
      tgt_y_in   = tgt_y_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      err_in     = err_ff;
      x_dir_in   = x_dir_ff;
      y_dir_in   = y_dir_ff;
      x_major_in = x_major_ff;
      active_in  = active_ff;
      color_in   = color_ff;
      load_rsp   = 1'b0;

      dx  = (req_x_end >= req_x_start) ? req_x_end - req_x_start : req_x_start - req_x_end;
      dy  = (req_y_end >= req_y_start) ? req_y_end - req_y_start : req_y_start - req_y_end;
      fin = x_major_ff ? (cur_x_ff == tgt_x_ff) : (cur_y_ff == tgt_y_ff);
      err_sum = err_ff + ERR_BITS'(minor_ff);

      if (accept) begin
         unique case (cmd_type'(req_command))
            CMD_START: begin
               x_dir_in   = (req_x_end > req_x_start) ? DIR_POS :
                            (req_x_end < req_x_start) ? DIR_NEG : DIR_NONE;
               y_dir_in   = (req_y_end > req_y_start) ? DIR_POS :
                            (req_y_end < req_y_start) ? DIR_NEG : DIR_NONE;
               x_major_in = dy < dx;
               major_in   = (dy < dx) ? dx : dy;
               minor_in   = (dy < dx) ? dy : dx;
               err_in     = ERR_BITS'(major_in >> 1);
               cur_x_in   = req_x_start;
               cur_y_in   = req_y_start;
               tgt_x_in   = req_x_end;
               tgt_y_in   = req_y_end;
               color_in   = req_line_color;
               active_in  = 1'b1;
            end
            CMD_STEP: begin
               if (active_ff) begin
                  load_rsp = 1'b1;
                  if (fin) begin
                     active_in = 1'b0;
                  end else begin
                     err_in = err_sum;
                     if (err_sum > ERR_BITS'(major_ff)) begin
                        err_in = err_sum - ERR_BITS'(major_ff);
                        if (x_major_ff) cur_y_in = step_coord(cur_y_ff, y_dir_ff);
                        else            cur_x_in = step_coord(cur_x_ff, x_dir_ff);
                     end
                     if (x_major_ff) cur_x_in = step_coord(cur_x_ff, x_dir_ff);
                     else            cur_y_in = step_coord(cur_y_ff, y_dir_ff);
                  end
               end
            end
            default: ;
         endcase
      end

      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_res <= X_RES_RESET;
         cfg_ff.y_res <= Y_RES_RESET;
         cfg_ff.pitch <= PITCH_RESET;
         cfg_ff.bpp   <= BPP_RESET;
      end else if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_X_RES: cfg_ff.x_res <= csr_wdata[RES_BITS-1:0];
            CSR_Y_RES: cfg_ff.y_res <= csr_wdata[RES_BITS-1:0];
            CSR_PITCH: cfg_ff.pitch <= csr_wdata[PITCH_BITS-1:0];
            CSR_BPP:   cfg_ff.bpp   <= csr_wdata[BPP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         tgt_x_ff     <= '0;
         tgt_y_ff     <= '0;
         major_ff     <= '0;
         minor_ff     <= '0;
         err_ff       <= '0;
         x_dir_ff     <= DIR_NONE;
         y_dir_ff     <= DIR_NONE;
         x_major_ff   <= 1'b0;
         active_ff    <= 1'b0;
         color_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         tgt_x_ff     <= tgt_x_in;
         tgt_y_ff     <= tgt_y_in;
         major_ff     <= major_in;
         minor_ff     <= minor_in;
         err_ff       <= err_in;
         x_dir_ff     <= x_dir_in;
         y_dir_ff     <= y_dir_in;
         x_major_ff   <= x_major_in;
         active_ff    <= active_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, taken from the pixel before the step
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_x_ff     <= cur_x_ff;
         rsp_y_ff     <= cur_y_ff;
         rsp_off_ff   <= info.offset;
         rsp_color_ff <= color_ff;
         rsp_vis_ff   <= info.visible;
         rsp_last_ff  <= fin;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_byte_offset = rsp_off_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_visible     = rsp_vis_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### design/clr_checker.sv
module clr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_command,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input clr_pkg::coord_type                rsp_pixel_x,
   input clr_pkg::coord_type                rsp_pixel_y,
   input logic [clr_pkg::OFFSET_BITS-1:0]   rsp_byte_offset,
   input logic                              rsp_last
);
   import clr_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) &&
      $stable(rsp_pixel_y) && $stable(rsp_byte_offset) && $stable(rsp_last))
      else $error("stalled result beat changed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_START) |=> !rsp_valid)
      else $error("start beat produced a result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_command     (req_command),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_byte_offset (rsp_byte_offset),
   .rsp_last        (rsp_last)
);
